### src/orrf_pkg.sv
// ============================================================================
// orrf_pkg: shared types and constants for the overwrite/reset ring FIFO
// Field widths, status codes, config register map and the byte mask helper.
// ============================================================================
`default_nettype none

package orrf_pkg;

    // Parameter defaults
    localparam int unsigned DEPTH_DEF      = 16;
    localparam int unsigned ITEM_BYTES_DEF = 8;

    // Payload field widths
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEAD_W   = 2;

    // Configuration register widths and reset values
    localparam int unsigned DEPTH_REG_W = 5;
    localparam int unsigned ITEM_REG_W  = 4;
    localparam logic [DEPTH_REG_W-1:0] DEPTH_REG_RST = 5'd16;
    localparam logic [ITEM_REG_W-1:0]  ITEM_REG_RST  = 4'd8;

    // APB map: register i at byte address 4*i
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_DEPTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ITEM  = 1'b1;

    // Actions
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    localparam logic [LEAD_W-1:0] LEAD_MAX = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERRUN  = 2'd1,
        ST_UNDERRUN = 2'd2,
        ST_BAD_SIZE = 2'd3
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
        logic read_done;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pull_read;
    } t_dp_stat;

    // Ones in bytes below n; n of 8 or more gives all ones
    function automatic logic [DATA_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (CNT_W'(b) < n) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### src/orrf_ifs.sv
// ============================================================================
// orrf_ifs: valid/ready channel interfaces
// Request channel (push/pull items) and response channel (status, data).
// ============================================================================
`default_nettype none

interface orrf_in_if;
    import orrf_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [DATA_W-1:0] write_data;
    logic [CNT_W-1:0]  byte_count;

    modport source (output valid, output action, output write_data,
                    output byte_count, input ready);
    modport sink   (input valid, input action, input write_data,
                    input byte_count, output ready);
endinterface

interface orrf_out_if;
    import orrf_pkg::*;

    logic              valid;
    logic              ready;
    t_status           status;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output status, output read_data, input ready);
    modport sink   (input valid, input status, input read_data, output ready);
endinterface

`default_nettype wire

### src/orrf_ram.sv
// ============================================================================
// orrf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module orrf_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

### src/orrf_cfg.sv
// ============================================================================
// orrf_cfg: APB configuration registers
// Holds the depth-in-use and item-size registers; zero-wait writes and reads.
// ============================================================================
`default_nettype none

module orrf_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [orrf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [orrf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [orrf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [orrf_pkg::DEPTH_REG_W-1:0] o_depth_reg,
    output logic      [orrf_pkg::ITEM_REG_W-1:0]  o_item_reg
);
    import orrf_pkg::*;

    logic [DEPTH_REG_W-1:0] r_depth;
    logic [ITEM_REG_W-1:0]  r_item;
    logic [REG_IDX_W-1:0]   w_idx;
    logic                   w_wr;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_REG_RST;
            r_item  <= ITEM_REG_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_DEPTH: r_depth <= pwdata[DEPTH_REG_W-1:0];
                REG_ITEM:  r_item  <= pwdata[ITEM_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DEPTH: prdata = APB_DATA_W'(r_depth);
            REG_ITEM:  prdata = APB_DATA_W'(r_item);
            default:   prdata = '0;
        endcase
    end

    assign o_depth_reg = r_depth;
    assign o_item_reg  = r_item;
endmodule

`default_nettype wire

### src/orrf_ctrl.sv
// ============================================================================
// orrf_ctrl: sequencer for the ring FIFO
// Accepts one transaction, runs it on the datapath, and owns the result valid.
// ============================================================================
`default_nettype none

module orrf_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output orrf_pkg::t_dp_cmd        o_cmd,
    input  wire orrf_pkg::t_dp_stat  i_stat
);
    import orrf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register can take a new value
                if (w_out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.pull_read) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_READ: begin
                o_cmd.read_done = 1'b1;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

`default_nettype wire

### src/orrf_dp.sv
// ============================================================================
// orrf_dp: ring FIFO datapath
// Positions, lap lead, slot RAM and the result register.
// ============================================================================
`default_nettype none

module orrf_dp #(
    parameter int unsigned DEPTH      = orrf_pkg::DEPTH_DEF,
    parameter int unsigned ITEM_BYTES = orrf_pkg::ITEM_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire orrf_pkg::t_dp_cmd                i_cmd,
    output orrf_pkg::t_dp_stat                    o_stat,
    input  wire logic [orrf_pkg::DEPTH_REG_W-1:0] i_depth_reg,
    input  wire logic [orrf_pkg::ITEM_REG_W-1:0]  i_item_reg,
    input  wire logic                             i_action,
    input  wire logic [orrf_pkg::DATA_W-1:0]      i_write_data,
    input  wire logic [orrf_pkg::CNT_W-1:0]       i_byte_count,
    output orrf_pkg::t_status                     o_status,
    output logic      [orrf_pkg::DATA_W-1:0]      o_read_data
);
    import orrf_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH + 1);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned SW = ITEM_BYTES * 8;

    // Latched transaction
    logic              r_action;
    logic [DATA_W-1:0] r_wdata;
    logic [CNT_W-1:0]  r_count;

    // FIFO state
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [LEAD_W-1:0] r_lead;
    logic [CNT_W-1:0]  r_rd_n;

    // Result register
    t_status           r_res_status;
    logic [DATA_W-1:0] r_res_data;

    logic [PW-1:0]     w_depth;
    logic [CNT_W-1:0]  w_isize;
    logic              w_size_bad;
    logic              w_overrun;
    logic              w_wp_wrap;
    logic [PW-1:0]     w_wp_use;
    logic              w_rp_wrap;
    logic [PW-1:0]     w_rp_use;
    logic [LEAD_W-1:0] w_lead_pull;
    logic              w_underrun;
    logic              w_push_ok;
    logic              w_pull_ok;
    logic [DATA_W-1:0] w_wdata_m;
    logic [SW-1:0]     w_ram_rdata;

    // Effective depth and item size from the registers
    always_comb begin
        if (i_depth_reg == '0) begin
            w_depth = PW'(1);
        end else if (32'(i_depth_reg) > DEPTH) begin
            w_depth = PW'(DEPTH);
        end else begin
            w_depth = PW'(i_depth_reg);
        end
        if (i_item_reg == '0) begin
            w_isize = CNT_W'(1);
        end else if (i_item_reg > CNT_W'(ITEM_BYTES)) begin
            w_isize = CNT_W'(ITEM_BYTES);
        end else begin
            w_isize = i_item_reg;
        end
    end

    assign w_size_bad = (r_count == '0) || (r_count > w_isize);

    // Push side: overrun is checked on the unwrapped write position
    assign w_overrun = (r_wp == r_rp) && (r_lead != '0);
    assign w_wp_wrap = (r_wp >= w_depth);
    assign w_wp_use  = w_wp_wrap ? '0 : r_wp;

    // Pull side: wrap first, then test for underrun
    assign w_rp_wrap   = (r_rp >= w_depth);
    assign w_rp_use    = w_rp_wrap ? '0 : r_rp;
    assign w_lead_pull = (w_rp_wrap && r_lead != '0) ? LEAD_W'(r_lead - 1'b1) : r_lead;
    assign w_underrun  = (w_rp_use == r_wp) && (w_lead_pull == '0);

    assign w_push_ok = (r_action == ACT_PUSH) && !w_size_bad && !w_overrun;
    assign w_pull_ok = (r_action == ACT_PULL) && !w_underrun;
    assign o_stat.pull_read = w_pull_ok;

    assign w_wdata_m = r_wdata & byte_mask(r_count);

    orrf_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && w_push_ok),
        .i_waddr (w_wp_use[AW-1:0]),
        .i_wdata (w_wdata_m[SW-1:0]),
        .i_re    (i_cmd.exec && w_pull_ok),
        .i_raddr (w_rp_use[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Transaction latch and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_wdata  <= i_write_data;
            r_count  <= i_byte_count;
        end
        if (i_cmd.exec) begin
            r_rd_n <= w_size_bad ? w_isize : r_count;
            if (!w_pull_ok) begin
                r_res_data <= '0;
                if (r_action == ACT_PULL) begin
                    r_res_status <= ST_UNDERRUN;
                end else if (w_size_bad) begin
                    r_res_status <= ST_BAD_SIZE;
                end else if (w_overrun) begin
                    r_res_status <= ST_OVERRUN;
                end else begin
                    r_res_status <= ST_OK;
                end
            end
        end
        if (i_cmd.read_done) begin
            r_res_status <= ST_OK;
            r_res_data   <= DATA_W'(w_ram_rdata) & byte_mask(r_rd_n);
        end
    end

    // Positions and lap lead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_lead <= '0;
        end else if (i_cmd.exec) begin
            if (r_action == ACT_PUSH) begin
                if (!w_size_bad) begin
                    if (w_overrun) begin
                        // drop the data and restart from the reader
                        r_wp   <= r_rp;
                        r_lead <= '0;
                    end else begin
                        r_wp <= PW'(w_wp_use + 1'b1);
                        if (w_wp_wrap && r_lead != LEAD_MAX) begin
                            r_lead <= LEAD_W'(r_lead + 1'b1);
                        end
                    end
                end
            end else begin
                r_lead <= w_lead_pull;
                r_rp   <= w_underrun ? w_rp_use : PW'(w_rp_use + 1'b1);
            end
        end
    end

    assign o_status    = r_res_status;
    assign o_read_data = r_res_data;
endmodule

`default_nettype wire

### src/overwrite_reset_ring_fifo.sv
// ============================================================================
// overwrite_reset_ring_fifo: ring FIFO with lap lead count
// Push/pull transactions on a slot RAM; overrun restarts at the read position.
// ============================================================================
//
//  Channel   Direction  Handshake          Payload
//  i_in      sink       valid / ready      action, write_data, byte_count
//  o_out     source     valid / ready      status, read_data
//  APB       slave      psel/penable/...   depth_in_use @0x0, item_bytes @0x4
//
//  After acceptance, S_EXEC updates the positions and accesses the slot RAM
//  once o_out is free; a push or underrun result is registered as S_EXEC ends,
//  and a pull that reads the RAM passes S_EXEC and then S_READ (registered RAM
//  read). i_in.ready is low in S_EXEC and S_READ.
//  Reset (i_rst_n low, synchronous) clears positions, lap lead and result valid
//  and loads depth 16 and item size 8; slot contents are kept. A transaction
//  accepted while a result waits on o_out holds its execution until it is taken.
//
`default_nettype none

module overwrite_reset_ring_fifo #(
    parameter int unsigned DEPTH      = orrf_pkg::DEPTH_DEF,
    parameter int unsigned ITEM_BYTES = orrf_pkg::ITEM_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    orrf_in_if.sink                              i_in,
    orrf_out_if.source                           o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [orrf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [orrf_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [orrf_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import orrf_pkg::*;

    logic [DEPTH_REG_W-1:0] w_depth_reg;
    logic [ITEM_REG_W-1:0]  w_item_reg;
    t_dp_cmd                w_cmd;
    t_dp_stat               w_stat;
    logic                   w_in_ready;
    logic                   w_out_valid;
    t_status                w_status;
    logic [DATA_W-1:0]      w_read_data;

    orrf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_depth_reg (w_depth_reg),
        .o_item_reg  (w_item_reg)
    );

    orrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    orrf_dp #(
        .DEPTH      (DEPTH),
        .ITEM_BYTES (ITEM_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_depth_reg  (w_depth_reg),
        .i_item_reg   (w_item_reg),
        .i_action     (i_in.action),
        .i_write_data (i_in.write_data),
        .i_byte_count (i_in.byte_count),
        .o_status     (w_status),
        .o_read_data  (w_read_data)
    );

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = w_out_valid;
    assign o_out.status    = w_status;
    assign o_out.read_data = w_read_data;
endmodule

`default_nettype wire

### src/orrf_checker.sv
// ============================================================================
// orrf_checker: port-level checks for the ring FIFO
// Watches the request and response channels of the top level.
// ============================================================================
`default_nettype none

module orrf_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [orrf_pkg::STATUS_W-1:0] i_out_status,
    input wire logic [orrf_pkg::DATA_W-1:0]   i_out_data
);
    import orrf_pkg::*;

    // result valid drops during reset
    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // hold a stalled result
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one transaction in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transaction accepted back to back");

    // every non-ok status carries zero data
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> (i_out_data == '0))
        else $error("nonzero data with error status");
endmodule

bind overwrite_reset_ring_fifo orrf_checker u_orrf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_data   (o_out.read_data)
);

`default_nettype wire
